### hw/rtl/u8eb_pkg.sv
// Package for the UTF-8 encoder with per-string byte budget.
// Holds status codes, encoding range bounds and lead/continuation byte marks.
// No dependencies.
package u8eb_pkg;

    localparam int CP_W    = 21;
    localparam int COUNT_W = 16;
    localparam int BYTE_W  = 8;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_OK      = 2'd0;
    localparam status_t STATUS_TRUNC   = 2'd1;
    localparam status_t STATUS_INVALID = 2'd2;

    typedef enum logic [0:0] {
        REG_LIMIT_ENABLE = 1'b0,
        REG_BYTE_LIMIT   = 1'b1
    } reg_index_t;

    localparam logic [CP_W-1:0] MAX_1BYTE = 21'h00007F;
    localparam logic [CP_W-1:0] MAX_2BYTE = 21'h0007FF;
    localparam logic [CP_W-1:0] MAX_3BYTE = 21'h00FFFF;
    localparam logic [CP_W-1:0] MAX_CP    = 21'h10FFFF;

    localparam logic [BYTE_W-1:0] LEAD_2  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD_3  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_4  = 8'hF0;
    localparam logic [BYTE_W-1:0] CONT    = 8'h80;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

endpackage

### hw/rtl/utf8_encoder_byte_budget.sv
// Top level: UTF-8 encoder with a per-string byte budget.
// Encodes one code point per input beat into up to four byte beats.
// Depends on u8eb_pkg.
//
//  channel | signals                                   | dir | role
//  --------+-------------------------------------------+-----+-------------------------
//  in      | in_valid in_ready code_point first_of_string | in  | one code point per beat
//  out     | out_valid out_ready out_byte status last_of_item | out | one byte or status per beat
//  cfg     | cfg_we cfg_index cfg_wdata                 | in  | register writes, no wait
//
// An accepted code point is encoded in the cycle it is accepted and loaded into
// the result register; it then gives 1 to 4 output beats, one per cycle while out_ready is high.
// A new code point is taken in the same cycle the last beat of the previous one
// leaves, so the input takes no new item while bytes of the last one remain.
// Reset clears the budget registers, the running count, the stop mark and out_valid.
// A stalled output holds its beat and blocks the input until the last beat goes.
module utf8_encoder_byte_budget (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [u8eb_pkg::COUNT_W-1:0]    cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [u8eb_pkg::CP_W-1:0]       code_point,
    input  logic                            first_of_string,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [u8eb_pkg::BYTE_W-1:0]     out_byte,
    output u8eb_pkg::status_t               status,
    output logic                            last_of_item
);

    logic                                limit_enable_reg;
    logic [u8eb_pkg::COUNT_W-1:0]        byte_limit_reg;
    logic [u8eb_pkg::COUNT_W-1:0]        count_reg;
    logic [u8eb_pkg::COUNT_W-1:0]        count_next;
    logic                                stopped_reg;
    logic                                stopped_next;

    logic                                valid_reg;
    logic [1:0]                          left_reg;
    logic [1:0]                          left_next;
    u8eb_pkg::status_t                   status_reg;
    u8eb_pkg::status_t                   status_next;
    logic [3:0][u8eb_pkg::BYTE_W-1:0]    bytes_reg;
    logic [3:0][u8eb_pkg::BYTE_W-1:0]    bytes_next;

    logic                                in_fire;
    logic                                out_fire;
    logic [u8eb_pkg::COUNT_W-1:0]        base_count;
    logic                                base_stopped;
    logic [2:0]                          n_bytes;
    logic [3:0][u8eb_pkg::BYTE_W-1:0]    enc;
    logic [u8eb_pkg::COUNT_W:0]          total;
    logic                                over;

    assign out_valid    = valid_reg;
    assign out_byte     = bytes_reg[0];
    assign status       = status_reg;
    assign last_of_item = (left_reg == 2'd0);
    assign out_fire     = valid_reg && out_ready;
    assign in_ready     = !valid_reg || (out_ready && left_reg == 2'd0);
    assign in_fire      = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_enable_reg <= 1'b0;
            byte_limit_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (u8eb_pkg::reg_index_t'(cfg_index))
                u8eb_pkg::REG_LIMIT_ENABLE: limit_enable_reg <= cfg_wdata[0];
                u8eb_pkg::REG_BYTE_LIMIT:   byte_limit_reg   <= cfg_wdata;
                default:                    limit_enable_reg <= limit_enable_reg;
            endcase
        end
    end

    // Encode the incoming code point
    always_comb
    begin
        enc = '0;
        if (code_point <= u8eb_pkg::MAX_1BYTE)
        begin
            n_bytes = 3'd1;
            enc[0]  = {1'b0, code_point[6:0]};
        end
        else if (code_point <= u8eb_pkg::MAX_2BYTE)
        begin
            n_bytes = 3'd2;
            enc[0]  = u8eb_pkg::LEAD_2 | {3'b000, code_point[10:6]};
            enc[1]  = u8eb_pkg::CONT | {2'b00, code_point[5:0]};
        end
        else if (code_point <= u8eb_pkg::MAX_3BYTE)
        begin
            n_bytes = 3'd3;
            enc[0]  = u8eb_pkg::LEAD_3 | {4'b0000, code_point[15:12]};
            enc[1]  = u8eb_pkg::CONT | {2'b00, code_point[11:6]};
            enc[2]  = u8eb_pkg::CONT | {2'b00, code_point[5:0]};
        end
        else
        begin
            n_bytes = 3'd4;
            enc[0]  = u8eb_pkg::LEAD_4 | {5'b00000, code_point[20:18]};
            enc[1]  = u8eb_pkg::CONT | {2'b00, code_point[17:12]};
            enc[2]  = u8eb_pkg::CONT | {2'b00, code_point[11:6]};
            enc[3]  = u8eb_pkg::CONT | {2'b00, code_point[5:0]};
        end
    end

    assign base_count   = first_of_string ? '0 : count_reg;
    assign base_stopped = first_of_string ? 1'b0 : stopped_reg;
    assign total        = {1'b0, base_count} + {{(u8eb_pkg::COUNT_W-2){1'b0}}, n_bytes};
    assign over         = limit_enable_reg && (total > {1'b0, byte_limit_reg});

    // Decide the item's outcome and load the result register
    always_comb
    begin
        count_next   = count_reg;
        stopped_next = stopped_reg;
        left_next    = left_reg;
        status_next  = status_reg;
        bytes_next   = bytes_reg;
        if (in_fire)
        begin
            count_next   = base_count;
            stopped_next = base_stopped;
            left_next    = 2'd0;
            bytes_next   = '0;
            if (base_stopped)
            begin
                status_next = u8eb_pkg::STATUS_TRUNC;
            end
            else if (code_point > u8eb_pkg::MAX_CP)
            begin
                status_next = u8eb_pkg::STATUS_INVALID;
            end
            else if (over)
            begin
                status_next  = u8eb_pkg::STATUS_TRUNC;
                stopped_next = 1'b1;
            end
            else
            begin
                status_next = u8eb_pkg::STATUS_OK;
                bytes_next  = enc;
                left_next   = 2'(n_bytes - 3'd1);
                count_next  = total[u8eb_pkg::COUNT_W] ? u8eb_pkg::COUNT_MAX
                                                       : total[u8eb_pkg::COUNT_W-1:0];
            end
        end
        else if (out_fire && left_reg != 2'd0)
        begin
            // advance to the next byte of the item
            bytes_next = {{u8eb_pkg::BYTE_W{1'b0}}, bytes_reg[3:1]};
            left_next  = left_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            stopped_reg <= 1'b0;
            valid_reg   <= 1'b0;
            left_reg    <= 2'd0;
            status_reg  <= u8eb_pkg::STATUS_OK;
        end
        else
        begin
            count_reg   <= count_next;
            stopped_reg <= stopped_next;
            left_reg    <= left_next;
            status_reg  <= status_next;
            if (in_fire)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_fire && left_reg == 2'd0)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

    a_status_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && status_reg != u8eb_pkg::STATUS_OK |-> left_reg == 2'd0)
        else $error("status beat is not the last beat of its item");

    a_status_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && status_reg != u8eb_pkg::STATUS_OK |-> bytes_reg[0] == '0)
        else $error("status beat carries a nonzero byte");

    a_no_take_midway: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && left_reg != 2'd0 |-> !in_ready)
        else $error("input taken while bytes of an item remain");

    a_next_byte_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && left_reg != 2'd0 |=> valid_reg && left_reg == $past(left_reg) - 2'd1)
        else $error("byte sequence of an item broke off");

    a_trunc_sets_stop: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !base_stopped && code_point <= u8eb_pkg::MAX_CP && over |=> stopped_reg)
        else $error("over-budget item did not stop the string");

endmodule
